[rtl/core/deformable_trilinear_volume_sampler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the trilinear volume sampler
// Wrappers for concurrent checks; they expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef DEFORMABLE_TRILINEAR_VOLUME_SAMPLER_UNIT_DEFINES_SVH
`define DEFORMABLE_TRILINEAR_VOLUME_SAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DTVS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTVS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define DTVS_ASSERT(label, clk, rst, prop, msg)
`define DTVS_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

[rtl/core/dtvs_pkg.sv]
// ----------------------------------------------------------------------------
// dtvs_pkg
// Shared constants and codes of the trilinear volume sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package dtvs_pkg;

  localparam int DEF_MAX_LENGTH = 16;
  localparam int DEF_MAX_HEIGHT = 16;
  localparam int DEF_MAX_WIDTH  = 16;
  localparam int DEF_VALUE_BITS = 16;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int OUT_BITS   = 24;
  localparam int BASE_BITS  = 7;
  localparam int OFF_BITS   = 16;
  localparam int COORD_BITS = 4;
  localparam int VOXEL_BITS = 16;
  localparam int SIZE_BITS  = 5;
  localparam int CFG_IDX_BITS = 2;
  localparam int EFF_BITS   = 9;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VOL_LENGTH = 2'd0,
    REG_VOL_HEIGHT = 2'd1,
    REG_VOL_WIDTH  = 2'd2,
    REG_NONE       = 2'd3
  } cfg_reg_t;

  // effective axis size: zero reads as one, large values saturate
  function automatic logic [EFF_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] r,
                                                   input logic [EFF_BITS-1:0] maxv);
    logic [EFF_BITS-1:0] e;
    e = EFF_BITS'(r);
    if (r == '0) e = EFF_BITS'(1);
    else if (e > maxv) e = maxv;
    return e;
  endfunction

endpackage
`default_nettype wire

[rtl/core/dtvs_ram.sv]
// ----------------------------------------------------------------------------
// dtvs_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module dtvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/deformable_trilinear_volume_sampler_unit.sv]
// ----------------------------------------------------------------------------
// deformable_trilinear_volume_sampler_unit
// Voxel store with trilinear sampling at learned fractional offsets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per item. command
//   CMD_WRITE stores voxel_value at (voxel_l, voxel_h, voxel_w) and returns
//   nothing; CMD_SAMPLE returns one beat on the output channel
//   (out_valid/out_stall) with sample_value and the outside flag.
//   Config port (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the volume
//   size in use; cfg_ready is always high. Write it only while idle.
//   The store is split into eight banks by coordinate parity, so all eight
//   corners are read together: one item per cycle is sustained while
//   out_stall does not hold a waiting beat. A sample passes the bank read
//   at the accepting edge, then column lerp, row lerp and frame lerp into
//   the output register.
//   When out_stall holds a waiting beat, the whole pipeline freezes and
//   in_stall rises in the same cycle. Reset clears the pipeline valids and
//   sets all sizes to 16; voxel contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deformable_trilinear_volume_sampler_unit_defines.svh"
module deformable_trilinear_volume_sampler_unit #(
  parameter int MAX_LENGTH = dtvs_pkg::DEF_MAX_LENGTH,
  parameter int MAX_HEIGHT = dtvs_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = dtvs_pkg::DEF_MAX_WIDTH,
  parameter int VALUE_BITS = dtvs_pkg::DEF_VALUE_BITS,
  parameter int FRAC_BITS  = dtvs_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [dtvs_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [dtvs_pkg::SIZE_BITS-1:0]          cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic                                    command,
  input  wire logic [dtvs_pkg::COORD_BITS-1:0]         voxel_l,
  input  wire logic [dtvs_pkg::COORD_BITS-1:0]         voxel_h,
  input  wire logic [dtvs_pkg::COORD_BITS-1:0]         voxel_w,
  input  wire logic signed [dtvs_pkg::VOXEL_BITS-1:0]  voxel_value,
  input  wire logic signed [dtvs_pkg::BASE_BITS-1:0]   base_l,
  input  wire logic signed [dtvs_pkg::BASE_BITS-1:0]   base_h,
  input  wire logic signed [dtvs_pkg::BASE_BITS-1:0]   base_w,
  input  wire logic signed [dtvs_pkg::OFF_BITS-1:0]    off_l,
  input  wire logic signed [dtvs_pkg::OFF_BITS-1:0]    off_h,
  input  wire logic signed [dtvs_pkg::OFF_BITS-1:0]    off_w,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [dtvs_pkg::OUT_BITS-1:0]         sample_value,
  output logic                                         outside
);
  import dtvs_pkg::*;

  localparam int XL = ($clog2(MAX_LENGTH) < 2) ? 2 : $clog2(MAX_LENGTH);
  localparam int XH = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
  localparam int XW = ($clog2(MAX_WIDTH)  < 2) ? 2 : $clog2(MAX_WIDTH);
  localparam int AW = (XL - 1) + (XH - 1) + (XW - 1);
  localparam int BANK_DEPTH = 1 << AW;
  localparam int V  = VALUE_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = F + 24;            // position with sign and headroom
  localparam int WT = F + 2;             // signed weight
  localparam int CW = V + F + 2;         // column lerp
  localparam int PR = CW + WT + 1;       // row sum before shift
  localparam int RW = PR - F;
  localparam int PF = RW + WT + 1;       // frame sum before shift
  localparam int FV = PF - F;
  localparam int EW = (FV > OUT_BITS) ? FV : OUT_BITS;

  localparam logic signed [WT-1:0] ONE   = WT'(1 << F);
  localparam logic signed [PR-1:0] HALFR = PR'(1 << (F - 1));
  localparam logic signed [PF-1:0] HALFF = PF'(1 << (F - 1));
  localparam logic signed [EW-1:0] LIM_HI = EW'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] LIM_LO = -LIM_HI - EW'(1);

  // ---------------- configuration ----------------
  logic [SIZE_BITS-1:0] vol_length, vol_height, vol_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_length <= SIZE_BITS'(16);
      vol_height <= SIZE_BITS'(16);
      vol_width  <= SIZE_BITS'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOL_LENGTH: vol_length <= cfg_data;
        REG_VOL_HEIGHT: vol_height <= cfg_data;
        REG_VOL_WIDTH:  vol_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic adv, accept, s1_v, s2_v;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // ---------------- stage 0: locate, bank addressing ----------------
  logic [EFF_BITS-1:0] eff_l, eff_h, eff_w;
  logic signed [PW-1:0] p_l, p_h, p_w;
  logic [PW-1:0] lim_l, lim_h, lim_w;
  logic in_l, in_h, in_w;
  logic [XL-1:0] i0_l, i1_l;
  logic [XH-1:0] i0_h, i1_h;
  logic [XW-1:0] i0_w, i1_w;
  logic [F-1:0] f_l, f_h, f_w;
  logic cl_l, cl_h, cl_w;
  logic wr_ok;

  always_comb begin
    eff_l = eff_size(vol_length, EFF_BITS'(MAX_LENGTH));
    eff_h = eff_size(vol_height, EFF_BITS'(MAX_HEIGHT));
    eff_w = eff_size(vol_width,  EFF_BITS'(MAX_WIDTH));
    p_l = (PW'(base_l) <<< F) + PW'(off_l);
    p_h = (PW'(base_h) <<< F) + PW'(off_h);
    p_w = (PW'(base_w) <<< F) + PW'(off_w);
    lim_l = PW'(eff_l - EFF_BITS'(1)) << F;
    lim_h = PW'(eff_h - EFF_BITS'(1)) << F;
    lim_w = PW'(eff_w - EFF_BITS'(1)) << F;
    in_l = !p_l[PW-1] && (PW'(p_l) <= lim_l);
    in_h = !p_h[PW-1] && (PW'(p_h) <= lim_h);
    in_w = !p_w[PW-1] && (PW'(p_w) <= lim_w);
    i0_l = p_l[F +: XL];
    i0_h = p_h[F +: XH];
    i0_w = p_w[F +: XW];
    i1_l = i0_l + XL'(1);
    i1_h = i0_h + XH'(1);
    i1_w = i0_w + XW'(1);
    f_l = p_l[F-1:0];
    f_h = p_h[F-1:0];
    f_w = p_w[F-1:0];
    // high corner clamps to the last index
    cl_l = (EFF_BITS'(i0_l) == eff_l - EFF_BITS'(1));
    cl_h = (EFF_BITS'(i0_h) == eff_h - EFF_BITS'(1));
    cl_w = (EFF_BITS'(i0_w) == eff_w - EFF_BITS'(1));
    wr_ok = (EFF_BITS'(voxel_l) < EFF_BITS'(MAX_LENGTH)) &&
            (EFF_BITS'(voxel_h) < EFF_BITS'(MAX_HEIGHT)) &&
            (EFF_BITS'(voxel_w) < EFF_BITS'(MAX_WIDTH));
  end

  logic [XL-1:0] wl;
  logic [XH-1:0] wh;
  logic [XW-1:0] ww;
  logic [AW-1:0] waddr;
  logic [2:0]    wbank;

  assign wl    = XL'(voxel_l);
  assign wh    = XH'(voxel_h);
  assign ww    = XW'(voxel_w);
  assign waddr = {wl[XL-1:1], wh[XH-1:1], ww[XW-1:1]};
  assign wbank = {wl[0], wh[0], ww[0]};

  logic [V-1:0] rdata [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [XL-1:0] al;
    logic [XH-1:0] ah;
    logic [XW-1:0] aw;
    logic [AW-1:0] raddr;
    logic          we;

    // each bank holds one parity class; pick the corner index of that parity
    assign al = (i0_l[0] == b[2]) ? i0_l : i1_l;
    assign ah = (i0_h[0] == b[1]) ? i0_h : i1_h;
    assign aw = (i0_w[0] == b[0]) ? i0_w : i1_w;
    assign raddr = {al[XL-1:1], ah[XH-1:1], aw[XW-1:1]};
    assign we = accept && (cmd_t'(command) == CMD_WRITE) && wr_ok && (wbank == 3'(b));

    dtvs_ram #(
      .WIDTH (V),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (V'(voxel_value)),
      .re    (adv),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  // ---------------- stage 1: corner select, column lerp ----------------
  logic         s1_out;
  logic [F-1:0] s1_fl, s1_fh, s1_fw;
  logic [2:0]   s1_par, s1_clamp;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= accept && (cmd_t'(command) == CMD_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_out   <= !(in_l && in_h && in_w);
      s1_fl    <= f_l;
      s1_fh    <= f_h;
      s1_fw    <= f_w;
      s1_par   <= {i0_l[0], i0_h[0], i0_w[0]};
      s1_clamp <= {cl_l, cl_h, cl_w};
    end
  end

  logic signed [V-1:0] cv [8];     // index {dl, dh, dw}
  logic signed [WT-1:0] wlo_w, whi_w;
  logic signed [CW-1:0] col [4];   // index {dl, dh}

  for (genvar k = 0; k < 8; k++) begin : g_corner
    logic [2:0] sel;
    // high corner sits in the other parity bank unless clamped
    assign sel[2] = s1_par[2] ^ (k[2] & !s1_clamp[2]);
    assign sel[1] = s1_par[1] ^ (k[1] & !s1_clamp[1]);
    assign sel[0] = s1_par[0] ^ (k[0] & !s1_clamp[0]);
    assign cv[k]  = $signed(rdata[sel]);
  end

  assign whi_w = $signed(WT'(s1_fw));
  assign wlo_w = ONE - whi_w;

  for (genvar j = 0; j < 4; j++) begin : g_col
    assign col[j] = cv[2*j] * wlo_w + cv[2*j+1] * whi_w;
  end

  // ---------------- stage 2: row lerp ----------------
  logic signed [CW-1:0] s2_col [4];
  logic                 s2_out;
  logic [F-1:0]         s2_fl, s2_fh;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col <= col;
      s2_out <= s1_out;
      s2_fl  <= s1_fl;
      s2_fh  <= s1_fh;
    end
  end

  logic signed [WT-1:0] wlo_h, whi_h;
  logic signed [PR-1:0] rs0, rs1;

  assign whi_h = $signed(WT'(s2_fh));
  assign wlo_h = ONE - whi_h;
  assign rs0 = s2_col[0] * wlo_h + s2_col[1] * whi_h + HALFR;
  assign rs1 = s2_col[2] * wlo_h + s2_col[3] * whi_h + HALFR;

  // ---------------- stage 3: frame lerp, saturate ----------------
  logic signed [RW-1:0] s3_r0, s3_r1;
  logic                 s3_v, s3_out;
  logic [F-1:0]         s3_fl;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r0  <= $signed(rs0[PR-1:F]);
      s3_r1  <= $signed(rs1[PR-1:F]);
      s3_out <= s2_out;
      s3_fl  <= s2_fl;
    end
  end

  logic signed [WT-1:0] wlo_l, whi_l;
  logic signed [PF-1:0] fsum;
  logic signed [EW-1:0] fext;
  logic signed [OUT_BITS-1:0] sat;

  always_comb begin
    whi_l = $signed(WT'(s3_fl));
    wlo_l = ONE - whi_l;
    fsum  = s3_r0 * wlo_l + s3_r1 * whi_l + HALFF;
    fext  = EW'($signed(fsum[PF-1:F]));
    if (fext > LIM_HI)      sat = OUT_BITS'(LIM_HI);
    else if (fext < LIM_LO) sat = OUT_BITS'(LIM_LO);
    else                    sat = OUT_BITS'(fext);
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outside      <= s3_out;
      sample_value <= s3_out ? '0 : sat;
    end
  end

  // ---------------- checks ----------------
  `DTVS_ASSERT(a_outside_zero, clk, rst, (out_valid && outside) |-> (sample_value == '0), "outside beat with nonzero value")
  `DTVS_ASSERT_NEXT(a_write_no_result, clk, rst, accept && (cmd_t'(command) == CMD_WRITE), !s1_v, "write beat entered the sample pipe")
  `DTVS_ASSERT_NEXT(a_pipe_advance, clk, rst, s1_v && adv, s2_v, "sample lost between stages")
  `DTVS_ASSERT_NEXT(a_pipe_hold, clk, rst, s3_v && !adv, s3_v && $stable(s3_r0) && $stable(s3_r1), "frozen stage changed")

endmodule
`default_nettype wire
